/* src/tsu_pkg.sv */
package tsu_pkg;

	localparam int CMD_W   = 8;
	localparam int VAL_W   = 16;
	localparam int DLY_W   = 16;
	localparam int TIME_W  = 32;
	localparam int POS_W   = 6;
	localparam int COUNT_W = 7;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 2;

	localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
	localparam logic [OP_W-1:0] OP_READ   = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
	localparam logic [OP_W-1:0] OP_START  = 3'd3;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd4;
	localparam logic [OP_W-1:0] OP_POLL   = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_NO_INIT  = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] ST_OUT_BNDS = 2'd3;

	// Members are listed from the most significant bit down.
	typedef struct packed {
		logic [POS_W-1:0]        position;
		logic [DLY_W-1:0]        action_delay;
		logic signed [VAL_W-1:0] action_value;
		logic [CMD_W-1:0]        action_command;
		logic [TIME_W-1:0]       now_ms;
		logic [OP_W-1:0]         operation;
	} in_item_t;

	typedef struct packed {
		logic                    running;
		logic [COUNT_W-1:0]      stored_count;
		logic [DLY_W-1:0]        out_delay;
		logic signed [VAL_W-1:0] out_value;
		logic [CMD_W-1:0]        out_command;
		logic                    fired;
		logic [STAT_W-1:0]       status;
	} result_t;

	localparam int IN_BITS   = $bits(in_item_t);
	localparam int OUT_BITS  = $bits(result_t);
	localparam int IN_BYTES  = (IN_BITS + 7) / 8;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

	typedef struct packed {
		logic capture;
		logic execute;
	} dp_cmd_t;

endpackage

/* src/tsu_ctrl.sv */
module tsu_ctrl
	import tsu_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   s_tready_q;
	logic   m_tvalid_q;

	assign s_tready    = s_tready_q;
	assign m_tvalid    = m_tvalid_q;
	assign cmd.capture = s_tvalid & s_tready_q;
	assign cmd.execute = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			s_tready_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					s_tready_q <= 1'b1;
					if (s_tvalid && s_tready_q) begin
						state_q    <= S_EXEC;
						s_tready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					state_q    <= S_RESP;
					m_tvalid_q <= 1'b1;
				end
				S_RESP: begin
					if (m_tready) begin
						state_q    <= S_IDLE;
						m_tvalid_q <= 1'b0;
						s_tready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready_q && m_tvalid_q))
		else $error("input ready while a result is pending");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready_q) |=> ##1 m_tvalid_q)
		else $error("accepted item produced no result");

	a_exec_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> (state_q == S_RESP))
		else $error("execute step not followed by response");

endmodule

/* src/tsu_datapath.sv */
module tsu_datapath
	import tsu_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  in_item_t           item,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	output result_t            res
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int EXT_W = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
	localparam int CAP   = (TABLE_DEPTH > 127) ? 127 : TABLE_DEPTH;
	localparam logic [COUNT_W-1:0] CAP_V = COUNT_W'(CAP);
	localparam int ENT_W = CMD_W + VAL_W + DLY_W;

	logic [ENT_W-1:0]   mem_q [TABLE_DEPTH];
	logic [ENT_W-1:0]   rd_q;
	in_item_t           item_q;
	result_t            res_q;

	logic [COUNT_W-1:0] max_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] play_q;
	logic [TIME_W-1:0]  start_q;
	logic [TIME_W-1:0]  next_q;
	logic               exec_q;

	logic [EXT_W-1:0]   rd_addr_ext;
	logic [EXT_W-1:0]   wr_addr_ext;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   wr_addr;
	logic               do_write;

	logic [CMD_W-1:0]   rd_cmd;
	logic [VAL_W-1:0]   rd_val;
	logic [DLY_W-1:0]   rd_dly;
	logic [TIME_W-1:0]  elapsed;

	result_t            res_d;
	logic [COUNT_W-1:0] count_d;
	logic [COUNT_W-1:0] play_d;
	logic [TIME_W-1:0]  start_d;
	logic [TIME_W-1:0]  next_d;
	logic               exec_d;

	// Reads use the table position for a read and the play position otherwise.
	assign rd_addr_ext = (item.operation == OP_READ) ? EXT_W'(item.position)
	                                                 : EXT_W'(play_q);
	assign wr_addr_ext = EXT_W'(count_q);
	assign rd_addr     = rd_addr_ext[IDX_W-1:0];
	assign wr_addr     = wr_addr_ext[IDX_W-1:0];

	assign {rd_cmd, rd_val, rd_dly} = rd_q;
	assign elapsed = item_q.now_ms - start_q;
	assign res     = res_q;

	assign do_write = cmd.execute && (item_q.operation == OP_APPEND)
	                  && (max_q != '0) && (count_q < max_q);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
			rd_q   <= mem_q[rd_addr];
		end
		if (do_write) begin
			mem_q[wr_addr] <= {item_q.action_command, item_q.action_value,
			                   item_q.action_delay};
		end
		if (cmd.execute) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		res_d        = '0;
		count_d      = count_q;
		play_d       = play_q;
		start_d      = start_q;
		next_d       = next_q;
		exec_d       = exec_q;
		res_d.status = ST_OK;
		case (item_q.operation)
			OP_APPEND: begin
				if (max_q == '0) begin
					res_d.status = ST_NO_INIT;
				end else if (count_q >= max_q) begin
					res_d.status = ST_FULL;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			OP_READ: begin
				if (max_q == '0) begin
					res_d.status = ST_NO_INIT;
				end else if (COUNT_W'(item_q.position) >= count_q) begin
					res_d.status = ST_OUT_BNDS;
				end else begin
					res_d.out_command = rd_cmd;
					res_d.out_value   = rd_val;
					res_d.out_delay   = rd_dly;
				end
			end
			OP_CLEAR: begin
				exec_d  = 1'b0;
				count_d = '0;
			end
			OP_START: begin
				start_d = item_q.now_ms;
				play_d  = '0;
				next_d  = '0;
				exec_d  = 1'b1;
			end
			OP_STOP: begin
				exec_d = 1'b0;
			end
			OP_POLL: begin
				if ((count_q != '0) && exec_q) begin
					if (play_q >= count_q) begin
						exec_d = 1'b0;
					end else if (elapsed >= next_q) begin
						play_d            = play_q + 1'b1;
						res_d.fired       = 1'b1;
						res_d.out_command = rd_cmd;
						res_d.out_value   = rd_val;
						next_d            = next_q + TIME_W'(rd_dly);
					end
				end
			end
			default: begin
			end
		endcase
		res_d.stored_count = count_d;
		res_d.running      = exec_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '0;
			count_q <= '0;
			play_q  <= '0;
			start_q <= '0;
			next_q  <= '0;
			exec_q  <= 1'b0;
		end else if (cfg_we) begin
			// A capacity write also empties the table and halts playback.
			max_q   <= (cfg_wdata > CAP_V) ? CAP_V : cfg_wdata;
			count_q <= '0;
			exec_q  <= 1'b0;
		end else if (cmd.execute) begin
			count_q <= count_d;
			play_q  <= play_d;
			start_q <= start_d;
			next_q  <= next_d;
			exec_q  <= exec_d;
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= max_q)
		else $error("stored count above capacity");

	a_play_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		exec_q |-> (play_q <= count_q))
		else $error("play position beyond stored actions");

	a_fire_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.execute && res_d.fired) |=> (play_q == $past(play_q) + 1'b1))
		else $error("fired action did not advance play position");

endmodule

/* src/timed_action_sequencer_unit.sv */
// The result is offered after the execute step that follows acceptance (the table read is captured
// with the item) and stays offered until it is taken.
// The next item is accepted in the cycle after the result is taken.
// No new item is accepted while a result is pending.
// Reset clears the capacity, count, play state and timers; table contents stay
// undefined until appended.
module timed_action_sequencer_unit
	import tsu_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [COUNT_W-1:0]     cfg_wdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// operation, now_ms, action_command, action_value, action_delay, position
	input  logic [IN_BYTES*8-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// status, fired, out_command, out_value, out_delay, stored_count, running
	output logic [OUT_BYTES*8-1:0] m_tdata
);

	dp_cmd_t  cmd;
	in_item_t item;
	result_t  res;

	assign item    = in_item_t'(s_tdata[IN_BITS-1:0]);
	assign m_tdata = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, res};

	tsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	tsu_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);

endmodule

/* dv/sequencer_checker.sv */
module sequencer_checker
	import tsu_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [COUNT_W-1:0]     cfg_wdata,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_BYTES*8-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_BYTES*8-1:0] m_tdata,
	output int                     mismatches,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the script table and playback state.
	logic [CMD_W-1:0]        script_cmd [TABLE_DEPTH];
	logic signed [VAL_W-1:0] script_val [TABLE_DEPTH];
	logic [DLY_W-1:0]        script_dly [TABLE_DEPTH];
	logic [COUNT_W-1:0]      script_len;
	logic [COUNT_W-1:0]      cue_index;
	logic [TIME_W-1:0]       origin_ms;
	logic [TIME_W-1:0]       due_ms;
	logic                    playing;
	logic [COUNT_W-1:0]      capacity;

	result_t pending_results [$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	task automatic report_failure(input string msg);
		$display("[%0t] sequencer mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_failure($sformatf("%s got %0h, expected %0h", name, got, want));
		end
	endtask

	function automatic result_t advance_sequencer(input in_item_t it);
		result_t r;
		logic [TIME_W-1:0] elapsed;
		r = '0;
		elapsed = it.now_ms - origin_ms;
		case (it.operation)
			OP_APPEND: begin
				if (capacity == 0) begin
					r.status = ST_NO_INIT;
				end else if (script_len >= capacity || script_len >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					script_cmd[script_len] = it.action_command;
					script_val[script_len] = it.action_value;
					script_dly[script_len] = it.action_delay;
					script_len++;
				end
			end
			OP_READ: begin
				if (capacity == 0) begin
					r.status = ST_NO_INIT;
				end else if (it.position >= script_len || it.position >= TABLE_DEPTH) begin
					r.status = ST_OUT_BNDS;
				end else begin
					r.out_command = script_cmd[it.position];
					r.out_value = script_val[it.position];
					r.out_delay = script_dly[it.position];
				end
			end
			OP_CLEAR: begin
				playing = 1'b0;
				script_len = '0;
			end
			OP_START: begin
				origin_ms = it.now_ms;
				cue_index = '0;
				due_ms = '0;
				playing = 1'b1;
			end
			OP_STOP: begin
				playing = 1'b0;
			end
			OP_POLL: begin
				// The poll after the last action has fired ends playback without firing.
				if (script_len != 0 && playing) begin
					if (cue_index >= script_len || cue_index >= TABLE_DEPTH) begin
						playing = 1'b0;
					end else if (elapsed >= due_ms) begin
						r.fired = 1'b1;
						r.out_command = script_cmd[cue_index];
						r.out_value = script_val[cue_index];
						due_ms = due_ms + TIME_W'(script_dly[cue_index]);
						cue_index++;
					end
				end
			end
			default: begin
			end
		endcase
		r.stored_count = script_len;
		r.running = playing;
		return r;
	endfunction

	task automatic compare_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			report_failure($sformatf("result %h arrived with no item outstanding", got));
			return;
		end
		want = pending_results.pop_front();
		check_field("status", 32'(got.status), 32'(want.status));
		check_field("fired", 32'(got.fired), 32'(want.fired));
		check_field("out_command", 32'(got.out_command), 32'(want.out_command));
		check_field("out_value", 32'(got.out_value), 32'(want.out_value));
		check_field("out_delay", 32'(got.out_delay), 32'(want.out_delay));
		check_field("stored_count", 32'(got.stored_count), 32'(want.stored_count));
		check_field("running", 32'(got.running), 32'(want.running));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			script_len = '0;
			cue_index = '0;
			origin_ms = '0;
			due_ms = '0;
			playing = 1'b0;
			capacity = '0;
			pending_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				compare_result(m_tdata[OUT_BITS-1:0]);
			end
			if (cfg_we) begin
				// A capacity write saturates, empties the table and halts playback.
				capacity = (cfg_wdata > TABLE_DEPTH) ? COUNT_W'(TABLE_DEPTH) : cfg_wdata;
				script_len = '0;
				playing = 1'b0;
			end
			if (s_tvalid && s_tready) begin
				pending_results.push_back(advance_sequencer(s_tdata[IN_BITS-1:0]));
			end
		end
		outstanding = pending_results.size();
	end

endmodule

/* dv/testbench.sv */
module testbench
	import tsu_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [COUNT_W-1:0]     cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_BYTES*8-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_BYTES*8-1:0] m_tdata;

	int mismatches;
	int outstanding;
	int source_idle_pct = 0;
	int sink_idle_pct = 0;
	int hold_request = 0;
	int stall_left = 0;
	int items_sent = 0;

	logic [COUNT_W-1:0] capacity_plan [12] = '{7'd127, 7'd1, 7'd64, 7'd8, 7'd3, 7'd100,
		7'd16, 7'd0, 7'd64, 7'd2, 7'd33, 7'd12};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	timed_action_sequencer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sequencer_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// Result side: random back-pressure, plus long hold-offs on request.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	function automatic in_item_t build_item(input logic [OP_W-1:0] op,
			input logic [TIME_W-1:0] stamp, input logic [CMD_W-1:0] cmd,
			input logic signed [VAL_W-1:0] val, input logic [DLY_W-1:0] dly,
			input logic [POS_W-1:0] pos);
		in_item_t it;
		it.operation = op;
		it.now_ms = stamp;
		it.action_command = cmd;
		it.action_value = val;
		it.action_delay = dly;
		it.position = pos;
		return it;
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		it.operation = OP_W'($urandom_range(0, 7));
		it.now_ms = $urandom;
		it.action_command = CMD_W'($urandom_range(0, 255));
		it.action_value = VAL_W'($urandom_range(0, 65535));
		it.action_delay = DLY_W'($urandom_range(0, 65535));
		it.position = POS_W'($urandom_range(0, 63));
		return it;
	endfunction

	function automatic in_item_t random_op(input logic [OP_W-1:0] op);
		in_item_t it;
		it = noise_item();
		it.operation = op;
		return it;
	endfunction

	// Called and returns at a falling edge; tvalid stays high after the handshake
	// so back-to-back items need no gap.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < source_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= (IN_BYTES*8)'(it);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (it.operation <= OP_POLL) begin
			items_sent++;
		end
	endtask

	task automatic set_capacity(input logic [COUNT_W-1:0] value);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Load a short script, start it and poll it with a slowly advancing clock.
	task automatic play_script();
		in_item_t it;
		int n;
		int polls;
		logic [TIME_W-1:0] stamp;
		if ($urandom_range(1) != 0) begin
			send_item(random_op(OP_CLEAR));
		end
		n = $urandom_range(1, 6);
		repeat (n) begin
			it = random_op(OP_APPEND);
			if ($urandom_range(9) != 0) begin
				it.action_delay = DLY_W'($urandom_range(0, 24));
			end
			send_item(it);
		end
		if ($urandom_range(2) == 0) begin
			it = random_op(OP_READ);
			it.position = POS_W'($urandom_range(0, 8));
			send_item(it);
		end
		stamp = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 40) : $urandom;
		it = random_op(OP_START);
		it.now_ms = stamp;
		send_item(it);
		polls = $urandom_range(n, 3 * n + 3);
		repeat (polls) begin
			if ($urandom_range(29) == 0) begin
				send_item(random_op(OP_STOP));
			end else begin
				if ($urandom_range(19) == 0) begin
					stamp += $urandom;
				end else begin
					stamp += $urandom_range(0, 12);
				end
				it = random_op(OP_POLL);
				it.now_ms = stamp;
				send_item(it);
			end
		end
	endtask

	task automatic run_segment(input int quota);
		int target;
		target = items_sent + quota;
		while (items_sent < target) begin
			if ($urandom_range(99) < 70) begin
				play_script();
			end else begin
				send_item(noise_item());
			end
		end
	endtask

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		source_idle_pct = 12;
		sink_idle_pct = 56;

		// Nothing is configured yet: table operations refuse, playback arms anyway.
		send_item(build_item(OP_APPEND, 32'h0, 8'hFF, 16'sh7FFF, 16'hFFFF, 6'd0));
		send_item(build_item(OP_READ, 32'h0, 8'h00, 16'sh0000, 16'h0000, 6'd63));
		send_item(build_item(OP_START, 32'hFFFF_FFF0, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_POLL, 32'hFFFF_FFF0, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_SPARE_LO, 32'hFFFF_FFFF, 8'hFF, 16'shFFFF, 16'hFFFF, 6'd63));
		send_item(build_item(OP_SPARE_HI, 32'h0, 8'h00, 16'sh0000, 16'h0000, 6'd0));

		set_capacity(7'd2);
		send_item(build_item(OP_APPEND, 32'h0, 8'hFF, 16'sh8000, 16'hFFFF, 6'd0));
		send_item(build_item(OP_APPEND, 32'h0, 8'h00, 16'sh7FFF, 16'h0000, 6'd0));
		send_item(build_item(OP_APPEND, 32'h0, 8'h5A, 16'sh1234, 16'h0001, 6'd0));
		send_item(build_item(OP_READ, 32'h0, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_READ, 32'h0, 8'h00, 16'sh0000, 16'h0000, 6'd1));
		send_item(build_item(OP_READ, 32'h0, 8'h00, 16'sh0000, 16'h0000, 6'd2));
		send_item(build_item(OP_READ, 32'h0, 8'h00, 16'sh0000, 16'h0000, 6'd63));
		// Start just below the wrap point so the timestamp wraps through zero.
		send_item(build_item(OP_START, 32'hFFFF_FFF0, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_POLL, 32'hFFFF_FFF0, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_POLL, 32'h0000_0054, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_POLL, 32'h0000_FFEF, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_POLL, 32'h0001_0000, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_POLL, 32'h0001_0001, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_START, 32'h0000_0000, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_STOP, 32'h0, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_POLL, 32'hFFFF_FFFF, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_CLEAR, 32'h0, 8'h00, 16'sh0000, 16'h0000, 6'd0));
		send_item(build_item(OP_READ, 32'h0, 8'h00, 16'sh0000, 16'h0000, 6'd0));

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					source_idle_pct = 12;
					sink_idle_pct = 56;
				end
				1: begin
					source_idle_pct = 56;
					sink_idle_pct = 12;
				end
				default: begin
					source_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				set_capacity(capacity_plan[phase * 4 + seg]);
				// A long result-side hold-off while the source keeps offering items.
				if (phase == 2 && seg == 1) begin
					hold_request = 300;
				end
				run_segment(45);
			end
		end

		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
